>>> src/allele_frequency_log_ratio_core_assert.svh
// Assertion macros for the allele frequency / log ratio core.
// Included by the RTL files that carry concurrent checks.
`ifndef ALLELE_FREQUENCY_LOG_RATIO_CORE_ASSERT_SVH
`define ALLELE_FREQUENCY_LOG_RATIO_CORE_ASSERT_SVH

// same-cycle implication
`define AFL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("afl assertion failed");

// next-cycle implication
`define AFL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("afl assertion failed");

`endif

>>> src/afl_pkg.sv
// Shared types and constants for the allele frequency / log ratio core.
// No dependencies.
`timescale 1ns / 1ps

package afl_pkg;

    localparam int IN_W      = 32;
    localparam int EXP_W     = 5;
    localparam int EXP_BIAS  = 16;
    localparam int SQ_STEPS  = 17;
    localparam int FRAC_W    = 17;
    localparam int FRAC_OUT  = 16;
    localparam int LOG_W     = 22;
    localparam int LOG_LAT   = SQ_STEPS + 2;

    localparam int Q_W       = 24;
    localparam int BAF_W     = 17;
    localparam int QHALF     = 32768;
    localparam int QONE      = 65536;
    localparam int QSHIFT    = 15;
    localparam int Q_MAX     = 8388607;
    localparam int Q_MIN     = -8388608;

    localparam int DIFF_W    = 26;
    localparam int SDIF_W    = 25;
    localparam int PROD_W    = SDIF_W + DIFF_W;
    localparam int DIV_NUM_W = 50;
    localparam int DIV_DEN_W = 25;
    localparam int SUM_W     = DIV_NUM_W + 2;
    localparam int LRR_W     = SUM_W + 1;

    localparam int NUM_CFG   = 6;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_HOM_REF_DELTA = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOM_REF_SIZE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HET_DELTA     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HET_SIZE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOM_ALT_DELTA = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOM_ALT_SIZE  = 3'd5;

    typedef struct packed {
        logic [IN_W-1:0] intensity_x;
        logic [IN_W-1:0] intensity_y;
        logic            last_sample;
    } t_req;

    typedef struct packed {
        logic [Q_W-1:0]   contrast;
        logic [Q_W-1:0]   strength;
        logic             log_valid;
        logic [BAF_W-1:0] b_allele_freq;
        logic [Q_W-1:0]   log_r_ratio;
        logic             ratio_valid;
        logic             last_sample_res;
    } t_res;

endpackage

>>> src/afl_log2.sv
// Pipelined base-2 logarithm, unsigned Q16.16 in, signed Q6.16 out.
// Leading-one normalize, one squaring stage per fraction bit. Uses afl_pkg.
`timescale 1ns / 1ps

module afl_log2
    import afl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [IN_W-1:0]  i_value,
    output logic             o_valid,
    output logic [LOG_W-1:0] o_log
);

    logic              r_v [0:SQ_STEPS];
    logic [IN_W-1:0]   r_m [0:SQ_STEPS];
    logic [EXP_W-1:0]  r_e [0:SQ_STEPS];
    logic [FRAC_W-1:0] r_f [0:SQ_STEPS];
    logic [IN_W:0]     w_t [1:SQ_STEPS];
    logic [EXP_W-1:0]  w_lead;
    logic [FRAC_W:0]   w_rnd;
    logic [EXP_W:0]    w_es;
    logic              r_out_v;
    logic [LOG_W-1:0]  r_log;

    always_comb begin
        w_lead = '0;
        for (int i = 0; i < IN_W; i++) begin
            if (i_value[i]) begin
                w_lead = EXP_W'(i);
            end
        end
    end

    always_comb begin
        for (int k = 1; k <= SQ_STEPS; k++) begin
            w_t[k] = (IN_W+1)'((64'(r_m[k-1]) * 64'(r_m[k-1])) >> (IN_W - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= SQ_STEPS; k++) begin
                r_v[k] <= 1'b0;
            end
            r_out_v <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= SQ_STEPS; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_out_v <= r_v[SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_m[0] <= i_value << (~w_lead);
        r_e[0] <= w_lead;
        r_f[0] <= '0;
        for (int k = 1; k <= SQ_STEPS; k++) begin
            r_m[k] <= w_t[k][IN_W] ? w_t[k][IN_W:1] : w_t[k][IN_W-1:0];
            r_e[k] <= r_e[k-1];
            r_f[k] <= {r_f[k-1][FRAC_W-2:0], w_t[k][IN_W]};
        end
        r_log <= {w_es, {FRAC_OUT{1'b0}}} + LOG_W'(w_rnd[FRAC_W:1]);
    end

    assign w_rnd = (FRAC_W+1)'(r_f[SQ_STEPS]) + (FRAC_W+1)'(1);
    assign w_es  = (EXP_W+1)'({1'b0, r_e[SQ_STEPS]}) - (EXP_W+1)'(EXP_BIAS);

    assign o_valid = r_out_v;
    assign o_log   = r_log;

endmodule

>>> src/afl_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Unsigned numerator and nonzero divisor. Uses afl_pkg.
`timescale 1ns / 1ps

module afl_div
    import afl_pkg::*;
#(
    parameter int NUM_W = DIV_NUM_W,
    parameter int DEN_W = DIV_DEN_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_quot
);

    logic             r_v   [0:NUM_W-1];
    logic [DEN_W-1:0] r_rem [0:NUM_W-1];
    logic [NUM_W-1:0] r_num [0:NUM_W-1];
    logic [DEN_W-1:0] r_den [0:NUM_W-1];
    logic [NUM_W-1:0] r_q   [0:NUM_W-1];

    logic [DEN_W:0]   w_tr [0:NUM_W-1];
    logic [DEN_W-1:0] w_dn [0:NUM_W-1];
    logic [NUM_W-1:0] w_qp [0:NUM_W-1];
    logic             w_ge [0:NUM_W-1];
    logic [DEN_W-1:0] w_rm [0:NUM_W-1];

    always_comb begin
        w_dn[0] = i_den;
        w_tr[0] = {{DEN_W{1'b0}}, i_num[NUM_W-1]};
        w_qp[0] = '0;
        for (int k = 1; k < NUM_W; k++) begin
            w_dn[k] = r_den[k-1];
            w_tr[k] = {r_rem[k-1], r_num[k-1][NUM_W-1-k]};
            w_qp[k] = r_q[k-1];
        end
        for (int k = 0; k < NUM_W; k++) begin
            w_ge[k] = w_tr[k] >= {1'b0, w_dn[k]};
            w_rm[k] = w_ge[k] ? DEN_W'(w_tr[k] - {1'b0, w_dn[k]}) : w_tr[k][DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_W; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            r_v[0] <= i_valid;
            for (int k = 1; k < NUM_W; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_num[0] <= i_num;
        for (int k = 1; k < NUM_W; k++) begin
            r_num[k] <= r_num[k-1];
        end
        for (int k = 0; k < NUM_W; k++) begin
            r_den[k] <= w_dn[k];
            r_rem[k] <= w_rm[k];
            r_q[k]   <= {w_qp[k][NUM_W-2:0], w_ge[k]};
        end
    end

    assign o_valid = r_v[NUM_W-1];
    assign o_quot  = r_q[NUM_W-1];

endmodule

>>> src/allele_frequency_log_ratio_core.sv
// Path: input reg, log lanes, contrast, select, products, operands, dividers, sign, output.
// Throughput: one request per cycle; o_busy stays low and the receiver cannot stall.
// The two 19-stage log lanes and the 50-stage one-bit-per-stage dividers dominate latency.
// Reset (synchronous, active low) clears all valid bits and the six cluster registers.
// Depends on afl_pkg, afl_log2, afl_div and the assertion macro header.
`timescale 1ns / 1ps
`include "allele_frequency_log_ratio_core_assert.svh"

module allele_frequency_log_ratio_core
    import afl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  t_req                 i_req,
    output logic                 o_busy,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [Q_W-1:0]       i_cfg_data,
    output logic                 o_res_valid,
    output t_res                 o_res
);

    typedef struct packed {
        logic                    last;
        logic                    lv;
        logic                    rv;
        logic signed [Q_W-1:0]   dl;
        logic signed [Q_W-1:0]   sz;
        logic [BAF_W-1:0]        base1;
        logic signed [Q_W-1:0]   base2;
    } t_carry;

    typedef struct packed {
        logic last;
        logic lv;
    } t_lside;

    typedef struct packed {
        t_carry c;
        logic   neg1;
        logic   neg2;
    } t_dside;

    localparam logic signed [SUM_W-1:0] B_HI = SUM_W'(QONE);
    localparam logic signed [LRR_W-1:0] L_HI = LRR_W'(Q_MAX);
    localparam logic signed [LRR_W-1:0] L_LO = LRR_W'(Q_MIN);

    logic signed [Q_W-1:0] r_cfg [0:NUM_CFG-1];

    // input stage
    logic r_in_v;
    t_req r_in;

    // log lanes
    logic              w_lx_v, w_ly_v;
    logic [LOG_W-1:0]  w_lx, w_ly;
    t_lside            r_ls [0:LOG_LAT-1];
    logic [LOG_W:0]    w_dl, w_sum;

    // contrast / strength
    logic   r_c_v;
    t_carry r_c;

    // cluster side select
    logic signed [DIFF_W-1:0] w_d, w_aa, w_ab, w_bb;
    logic signed [SDIF_W-1:0] w_aas, w_abs, w_bbs;
    logic                     w_eq, w_sa, w_sb;
    t_carry                   w_s;
    logic signed [DIFF_W-1:0] w_diff;
    logic signed [SDIF_W-1:0] w_sdiff, w_den1, w_den2;
    logic                     r_s_v;
    t_carry                   r_s;
    logic signed [DIFF_W-1:0] r_s_diff;
    logic signed [SDIF_W-1:0] r_s_sdiff, r_s_den1, r_s_den2;

    // products
    logic signed [PROD_W-1:0] w_n2;
    logic                     r_m_v;
    t_carry                   r_m;
    logic signed [PROD_W-1:0] r_m_n1, r_m_n2;
    logic signed [SDIF_W-1:0] r_m_den1, r_m_den2;

    // divider operands
    logic [PROD_W-1:0]    w_a1, w_a2;
    logic [DIV_DEN_W-1:0] w_ud1, w_ud2;
    logic                 r_d_v;
    t_dside               r_d;
    logic [DIV_NUM_W-1:0] r_d_num1, r_d_num2;
    logic [DIV_DEN_W-1:0] r_d_den1, r_d_den2;

    // divider outputs
    logic                 w_q1_v, w_q2_v;
    logic [DIV_NUM_W-1:0] w_q1, w_q2;
    t_dside               r_ds [0:DIV_NUM_W-1];

    // signed quotients plus base
    logic [SUM_W-1:0]        w_sq1, w_sq2;
    logic                    r_f_v;
    t_carry                  r_f;
    logic signed [SUM_W-1:0] r_f_s1, r_f_s2;

    // output stage
    logic signed [LRR_W-1:0] w_l;
    t_res                    w_res;
    logic                    r_out_v;
    t_res                    r_out;

    // ------------------------------------------------------------------ config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CFG; i++) begin
                r_cfg[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HOM_REF_DELTA: r_cfg[0] <= i_cfg_data;
                CFG_HOM_REF_SIZE:  r_cfg[1] <= i_cfg_data;
                CFG_HET_DELTA:     r_cfg[2] <= i_cfg_data;
                CFG_HET_SIZE:      r_cfg[3] <= i_cfg_data;
                CFG_HOM_ALT_DELTA: r_cfg[4] <= i_cfg_data;
                CFG_HOM_ALT_SIZE:  r_cfg[5] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------ valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_c_v   <= 1'b0;
            r_s_v   <= 1'b0;
            r_m_v   <= 1'b0;
            r_d_v   <= 1'b0;
            r_f_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_in_v  <= i_start && !o_busy;
            r_c_v   <= w_lx_v && w_ly_v;
            r_s_v   <= r_c_v;
            r_m_v   <= r_s_v;
            r_d_v   <= r_m_v;
            r_f_v   <= w_q1_v && w_q2_v;
            r_out_v <= r_f_v;
        end
    end

    // ------------------------------------------------------------------ input
    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_in <= i_req;
        end
    end

    afl_log2 u_log_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_v),
        .i_value (r_in.intensity_x),
        .o_valid (w_lx_v),
        .o_log   (w_lx)
    );

    afl_log2 u_log_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_v),
        .i_value (r_in.intensity_y),
        .o_valid (w_ly_v),
        .o_log   (w_ly)
    );

    always_ff @(posedge i_clk) begin
        r_ls[0].last <= r_in.last_sample;
        r_ls[0].lv   <= (r_in.intensity_x != '0) && (r_in.intensity_y != '0);
        for (int i = 1; i < LOG_LAT; i++) begin
            r_ls[i] <= r_ls[i-1];
        end
    end

    // ------------------------------------------------------------------ contrast / strength
    assign w_dl  = {w_lx[LOG_W-1], w_lx} - {w_ly[LOG_W-1], w_ly};
    assign w_sum = {w_lx[LOG_W-1], w_lx} + {w_ly[LOG_W-1], w_ly};

    always_ff @(posedge i_clk) begin
        r_c.last  <= r_ls[LOG_LAT-1].last;
        r_c.lv    <= r_ls[LOG_LAT-1].lv;
        r_c.rv    <= 1'b0;
        r_c.base1 <= '0;
        r_c.base2 <= '0;
        if (r_ls[LOG_LAT-1].lv) begin
            r_c.dl <= {{(Q_W-LOG_W-1){w_dl[LOG_W]}}, w_dl};
            r_c.sz <= {{(Q_W-LOG_W){w_sum[LOG_W]}}, w_sum[LOG_W:1]};
        end else begin
            r_c.dl <= '0;
            r_c.sz <= '0;
        end
    end

    // ------------------------------------------------------------------ side select
    assign w_d   = DIFF_W'(r_c.dl);
    assign w_aa  = DIFF_W'(r_cfg[0]);
    assign w_ab  = DIFF_W'(r_cfg[2]);
    assign w_bb  = DIFF_W'(r_cfg[4]);
    assign w_aas = SDIF_W'(r_cfg[1]);
    assign w_abs = SDIF_W'(r_cfg[3]);
    assign w_bbs = SDIF_W'(r_cfg[5]);

    assign w_eq = (w_d == w_ab);
    assign w_sa = ((w_d < w_ab) && (w_aa < w_ab)) || ((w_d > w_ab) && (w_aa > w_ab));
    assign w_sb = ((w_d > w_ab) && (w_bb > w_ab)) || ((w_d < w_ab) && (w_bb < w_ab));

    always_comb begin
        w_s     = r_c;
        w_diff  = '0;
        w_sdiff = '0;
        w_den1  = SDIF_W'(1);
        w_den2  = SDIF_W'(1);
        if (r_c.lv) begin
            if (w_eq) begin
                w_s.rv    = 1'b1;
                w_s.base1 = BAF_W'(QHALF);
                w_s.base2 = r_cfg[3];
            end else if (w_sa) begin
                w_s.rv    = 1'b1;
                w_s.base1 = '0;
                w_s.base2 = r_cfg[1];
                w_diff    = w_d - w_aa;
                w_sdiff   = w_aas - w_abs;
                w_den1    = SDIF_W'(w_ab - w_aa);
                w_den2    = SDIF_W'(w_aa - w_ab);
            end else if (w_sb) begin
                w_s.rv    = 1'b1;
                w_s.base1 = BAF_W'(QHALF);
                w_s.base2 = r_cfg[3];
                w_diff    = w_d - w_ab;
                w_sdiff   = w_bbs - w_abs;
                w_den1    = SDIF_W'(w_bb - w_ab);
                w_den2    = SDIF_W'(w_bb - w_ab);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s       <= w_s;
        r_s_diff  <= w_diff;
        r_s_sdiff <= w_sdiff;
        r_s_den1  <= w_den1;
        r_s_den2  <= w_den2;
    end

    // ------------------------------------------------------------------ products
    assign w_n2 = r_s_sdiff * r_s_diff;

    always_ff @(posedge i_clk) begin
        r_m      <= r_s;
        r_m_n1   <= PROD_W'(r_s_diff) <<< QSHIFT;
        r_m_n2   <= w_n2;
        r_m_den1 <= r_s_den1;
        r_m_den2 <= r_s_den2;
    end

    // ------------------------------------------------------------------ magnitudes, round-half
    assign w_a1  = r_m_n1[PROD_W-1] ? PROD_W'(-r_m_n1) : PROD_W'(r_m_n1);
    assign w_a2  = r_m_n2[PROD_W-1] ? PROD_W'(-r_m_n2) : PROD_W'(r_m_n2);
    assign w_ud1 = r_m_den1[SDIF_W-1] ? DIV_DEN_W'(-r_m_den1) : DIV_DEN_W'(r_m_den1);
    assign w_ud2 = r_m_den2[SDIF_W-1] ? DIV_DEN_W'(-r_m_den2) : DIV_DEN_W'(r_m_den2);

    always_ff @(posedge i_clk) begin
        r_d.c    <= r_m;
        r_d.neg1 <= r_m_n1[PROD_W-1] ^ r_m_den1[SDIF_W-1];
        r_d.neg2 <= r_m_n2[PROD_W-1] ^ r_m_den2[SDIF_W-1];
        r_d_num1 <= w_a1[DIV_NUM_W-1:0] + DIV_NUM_W'(w_ud1[DIV_DEN_W-1:1]);
        r_d_num2 <= w_a2[DIV_NUM_W-1:0] + DIV_NUM_W'(w_ud2[DIV_DEN_W-1:1]);
        r_d_den1 <= w_ud1;
        r_d_den2 <= w_ud2;
    end

    afl_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div_baf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_d_v),
        .i_num   (r_d_num1),
        .i_den   (r_d_den1),
        .o_valid (w_q1_v),
        .o_quot  (w_q1)
    );

    afl_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div_size (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_d_v),
        .i_num   (r_d_num2),
        .i_den   (r_d_den2),
        .o_valid (w_q2_v),
        .o_quot  (w_q2)
    );

    always_ff @(posedge i_clk) begin
        r_ds[0] <= r_d;
        for (int i = 1; i < DIV_NUM_W; i++) begin
            r_ds[i] <= r_ds[i-1];
        end
    end

    // ------------------------------------------------------------------ apply sign, add base
    assign w_sq1 = r_ds[DIV_NUM_W-1].neg1 ? SUM_W'(-{2'b00, w_q1}) : {2'b00, w_q1};
    assign w_sq2 = r_ds[DIV_NUM_W-1].neg2 ? SUM_W'(-{2'b00, w_q2}) : {2'b00, w_q2};

    always_ff @(posedge i_clk) begin
        r_f    <= r_ds[DIV_NUM_W-1].c;
        r_f_s1 <= SUM_W'(r_ds[DIV_NUM_W-1].c.base1) + w_sq1;
        r_f_s2 <= {{(SUM_W-Q_W){r_ds[DIV_NUM_W-1].c.base2[Q_W-1]}},
                   r_ds[DIV_NUM_W-1].c.base2} + w_sq2;
    end

    // ------------------------------------------------------------------ clamp, saturate
    assign w_l = {{(LRR_W-Q_W){r_f.sz[Q_W-1]}}, r_f.sz} - {r_f_s2[SUM_W-1], r_f_s2};

    always_comb begin
        w_res.contrast        = r_f.dl;
        w_res.strength        = r_f.sz;
        w_res.log_valid       = r_f.lv;
        w_res.ratio_valid     = r_f.rv;
        w_res.last_sample_res = r_f.last;
        w_res.b_allele_freq   = '0;
        w_res.log_r_ratio     = '0;
        if (r_f.rv) begin
            if (r_f_s1 < 0) begin
                w_res.b_allele_freq = '0;
            end else if (r_f_s1 > B_HI) begin
                w_res.b_allele_freq = BAF_W'(QONE);
            end else begin
                w_res.b_allele_freq = r_f_s1[BAF_W-1:0];
            end
            if (w_l > L_HI) begin
                w_res.log_r_ratio = L_HI[Q_W-1:0];
            end else if (w_l < L_LO) begin
                w_res.log_r_ratio = L_LO[Q_W-1:0];
            end else begin
                w_res.log_r_ratio = w_l[Q_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= w_res;
    end

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_out_v;
    assign o_res       = r_out;

    // ------------------------------------------------------------------ checks
    `AFL_ASSERT_IMPL(a_no_log_zero, i_clk, i_rst_n, o_res_valid && !o_res.log_valid, o_res.contrast == '0 && o_res.strength == '0 && !o_res.ratio_valid)
    `AFL_ASSERT_IMPL(a_ratio_needs_log, i_clk, i_rst_n, o_res_valid && o_res.ratio_valid, o_res.log_valid)
    `AFL_ASSERT_IMPL(a_baf_range, i_clk, i_rst_n, o_res_valid, o_res.b_allele_freq <= BAF_W'(QONE))
    `AFL_ASSERT_IMPL(a_div_lockstep, i_clk, i_rst_n, w_q1_v || w_q2_v, w_q1_v && w_q2_v)

endmodule
